// ===== src/ddc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddc_pkg: shared types and constants for the dual H-bridge command core
// Widths, command codes, stop modes, status codes and the result word.
// ----------------------------------------------------------------------------
package ddc_pkg;

    // full-scale command level
    localparam int MAX_PERMILLE = 1000;

    localparam int VALUE_W  = 16;                              // signed command fields
    localparam int PERIOD_W = 17;                              // period and compare values
    localparam int MAG_W    = $clog2(2 * MAX_PERMILLE + 1);    // |linear +- turn|
    localparam int LVL_W    = MAG_W + 1;                       // signed mixed level
    localparam int PROD_W   = PERIOD_W + MAG_W;                // serial product

    localparam logic [PERIOD_W-1:0] PERIOD_CAP = PERIOD_W'(65536);

    typedef enum logic [2:0] {
        OP_INIT       = 3'd0,
        OP_SET_OUTPUT = 3'd1,
        OP_DRIVE      = 3'd2,
        OP_STOP       = 3'd3,
        OP_ESTOP      = 3'd4
    } op_t;

    localparam logic [1:0] MODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_COAST   = 2'd1;
    localparam logic [1:0] MODE_BRAKE   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_INIT = 2'd1;
    localparam logic [1:0] ST_REFUSED  = 2'd2;

    // pin vector bit positions
    localparam int PIN_EN = 0;
    localparam int PIN_L1 = 1;
    localparam int PIN_L2 = 2;
    localparam int PIN_R1 = 3;
    localparam int PIN_R2 = 4;

    localparam logic [4:0] PINS_OFF = 5'b00000;
    localparam logic [4:0] PINS_ALL = 5'b11111;

    typedef struct packed {
        logic [4:0]          pins;
        logic [PERIOD_W-1:0] cmp_l;
        logic [PERIOD_W-1:0] cmp_r;
        logic [1:0]          status;
        logic                estop;
        logic [1:0]          mode;
    } result_t;

endpackage

// ===== src/dual_hbridge_motor_command_core.sv =====
// ----------------------------------------------------------------------------
// dual_hbridge_motor_command_core: differential-drive dual H-bridge control
// Decodes one command word per transfer (init, set output, drive, stop,
// emergency stop) and returns pin levels, PWM compares and status.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   command  | in_valid/in_ready  | operation, first_value, second_value,
//            |                    | stop_request, supply_safe
//   result   | out_valid/out_ready| bridge_enable, left/right_in1/in2,
//            |                    | left/right_compare, status,
//            |                    | emergency_latched, current_stop_mode
//   config   | cfg_we             | cfg_wdata (PWM period, counts)
//
// One command word at a time. Init, stop, emergency stop, refusals and
// unknown codes go from acceptance straight to the hand-over state. Set
// output and drive run one pass of the two bit-serial mul/div lanes; a drive
// whose mix exceeds full scale runs a second pass first (rescale). The lanes
// work one bit per cycle.
// A new command word is taken while the previous result still waits in the
// output register; a stalled result only holds the core at its hand-over.
// Reset clears all state; the period register resets to 1000.
// ----------------------------------------------------------------------------
module dual_hbridge_motor_command_core (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [ddc_pkg::PERIOD_W-1:0]  cfg_wdata,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    operation,
    input  logic signed [ddc_pkg::VALUE_W-1:0] first_value,
    input  logic signed [ddc_pkg::VALUE_W-1:0] second_value,
    input  logic [1:0]                    stop_request,
    input  logic                          supply_safe,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          bridge_enable,
    output logic                          left_in1,
    output logic                          left_in2,
    output logic                          right_in1,
    output logic                          right_in2,
    output logic [ddc_pkg::PERIOD_W-1:0]  left_compare,
    output logic [ddc_pkg::PERIOD_W-1:0]  right_compare,
    output logic [1:0]                    status,
    output logic                          emergency_latched,
    output logic [1:0]                    current_stop_mode
);
    import ddc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,    // rescale pass: |v| * MAX / peak
        S_CMP,      // compare pass: period * |v| / MAX
        S_PUT       // hand result to the output register
    } state_t;

    state_t              state_reg,   state_next;
    logic                start_reg,   start_next;
    logic [PERIOD_W-1:0] period_reg;
    logic                init_reg,    init_next;
    logic                estop_reg,   estop_next;
    logic [1:0]          mode_reg,    mode_next;
    logic [4:0]          pins_reg,    pins_next;
    logic [PERIOD_W-1:0] cmp_l_reg,   cmp_l_next;
    logic [PERIOD_W-1:0] cmp_r_reg,   cmp_r_next;
    logic [1:0]          status_reg,  status_next;
    logic                sgn_l_reg,   sgn_l_next;
    logic                sgn_r_reg,   sgn_r_next;
    logic [MAG_W-1:0]    mag_l_reg,   mag_l_next;
    logic [MAG_W-1:0]    mag_r_reg,   mag_r_next;
    logic [MAG_W-1:0]    peak_reg,    peak_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg,     out_next;

    // ---- clamp to +-full scale ----
    function automatic logic signed [LVL_W-1:0] clamp_level(
        input logic signed [VALUE_W-1:0] v
    );
        logic signed [VALUE_W-1:0] lim;
        lim = $signed(VALUE_W'(MAX_PERMILLE));
        if (v > lim)
        begin
            return LVL_W'(lim);
        end
        else if (v < -lim)
        begin
            return LVL_W'(-lim);
        end
        return LVL_W'(v);
    endfunction

    function automatic logic [MAG_W-1:0] abs_level(input logic signed [LVL_W-1:0] v);
        logic signed [LVL_W-1:0] n;
        n = -v;
        return v[LVL_W-1] ? MAG_W'(n) : MAG_W'(v);
    endfunction

    // ---- period as used: 0 reads as 1, above 65536 as 65536 ----
    logic [PERIOD_W-1:0] period_used;

    always_comb
    begin
        if (period_reg == '0)
        begin
            period_used = PERIOD_W'(1);
        end
        else if (period_reg > PERIOD_CAP)
        begin
            period_used = PERIOD_CAP;
        end
        else
        begin
            period_used = period_reg;
        end
    end

    // ---- command decode terms ----
    logic signed [LVL_W-1:0] cl1, cl2, lvl_l, lvl_r;
    logic [MAG_W-1:0]        abs_l, abs_r, peak;
    logic                    is_drive, mix_zero, need_scale;
    logic [1:0]              smode;
    op_t                     op;

    assign op       = op_t'(operation);
    assign cl1      = clamp_level(first_value);
    assign cl2      = clamp_level(second_value);
    assign is_drive = (op == OP_DRIVE);
    assign lvl_l    = is_drive ? (cl1 - cl2) : cl1;
    assign lvl_r    = is_drive ? (cl1 + cl2) : cl2;
    assign abs_l    = abs_level(lvl_l);
    assign abs_r    = abs_level(lvl_r);
    assign peak     = (abs_r > abs_l) ? abs_r : abs_l;
    assign mix_zero = (abs_l == '0) && (abs_r == '0);
    // a clamped set output never exceeds full scale, so only drive rescales
    assign need_scale = (peak > MAG_W'(MAX_PERMILLE));
    // unused stop code acts as standby
    assign smode = (stop_request > MODE_BRAKE) ? MODE_STANDBY : stop_request;

    // ---- arithmetic lanes ----
    logic [PERIOD_W-1:0] lane_a;
    logic [MAG_W-1:0]    lane_d;
    logic                done_l, done_r;
    logic [PERIOD_W-1:0] q_l, q_r;

    assign lane_a = (state_reg == S_SCALE) ? PERIOD_W'(MAX_PERMILLE) : period_used;
    assign lane_d = (state_reg == S_SCALE) ? peak_reg : MAG_W'(MAX_PERMILLE);

    ddc_muldiv u_lane_l (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .a     (lane_a),
        .b     (mag_l_reg),
        .d     (lane_d),
        .done  (done_l),
        .q     (q_l)
    );

    ddc_muldiv u_lane_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .a     (lane_a),
        .b     (mag_r_reg),
        .d     (lane_d),
        .done  (done_r),
        .q     (q_r)
    );

    // ---- sequencing ----
    logic force_off;
    logic dir_l1, dir_l2, dir_r1, dir_r2;

    // direction from the final (possibly rescaled) level; zero drives neither pin
    assign dir_l1 = (mag_l_reg != '0) && !sgn_l_reg;
    assign dir_l2 = (mag_l_reg != '0) &&  sgn_l_reg;
    assign dir_r1 = (mag_r_reg != '0) && !sgn_r_reg;
    assign dir_r2 = (mag_r_reg != '0) &&  sgn_r_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        init_next      = init_reg;
        estop_next     = estop_reg;
        mode_next      = mode_reg;
        pins_next      = pins_reg;
        cmp_l_next     = cmp_l_reg;
        cmp_r_next     = cmp_r_reg;
        status_next    = status_reg;
        sgn_l_next     = sgn_l_reg;
        sgn_r_next     = sgn_r_reg;
        mag_l_next     = mag_l_reg;
        mag_r_next     = mag_r_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        force_off      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = S_PUT;
                    status_next = ST_OK;
                    unique case (op) inside
                        OP_INIT:
                        begin
                            force_off = 1'b1;
                            if (estop_reg || !supply_safe)
                            begin
                                status_next = ST_REFUSED;
                            end
                            else
                            begin
                                init_next = 1'b1;
                            end
                        end
                        OP_SET_OUTPUT, OP_DRIVE:
                        begin
                            if (!init_reg)
                            begin
                                status_next = ST_NOT_INIT;   // nothing changes
                            end
                            else if (mix_zero)
                            begin
                                // behaves as a standby stop
                                force_off = 1'b1;
                                if (estop_reg)
                                begin
                                    status_next = ST_REFUSED;
                                end
                            end
                            else if (estop_reg || !supply_safe)
                            begin
                                force_off   = 1'b1;
                                status_next = ST_REFUSED;
                            end
                            else
                            begin
                                sgn_l_next = lvl_l[LVL_W-1];
                                sgn_r_next = lvl_r[LVL_W-1];
                                mag_l_next = abs_l;
                                mag_r_next = abs_r;
                                peak_next  = peak;
                                start_next = 1'b1;
                                state_next = (is_drive && need_scale) ? S_SCALE : S_CMP;
                            end
                        end
                        OP_STOP:
                        begin
                            if (!init_reg)
                            begin
                                force_off   = 1'b1;
                                status_next = ST_NOT_INIT;
                            end
                            else if (estop_reg || (smode != MODE_STANDBY && !supply_safe))
                            begin
                                force_off   = 1'b1;
                                status_next = ST_REFUSED;
                            end
                            else if (smode == MODE_BRAKE)
                            begin
                                pins_next  = PINS_ALL;
                                cmp_l_next = period_used;
                                cmp_r_next = period_used;
                                mode_next  = MODE_BRAKE;
                            end
                            else if (smode == MODE_COAST)
                            begin
                                pins_next         = PINS_OFF;
                                pins_next[PIN_EN] = 1'b1;
                                cmp_l_next        = period_used;
                                cmp_r_next        = period_used;
                                mode_next         = MODE_COAST;
                            end
                            else
                            begin
                                force_off = 1'b1;
                            end
                        end
                        OP_ESTOP:
                        begin
                            estop_next = 1'b1;
                            force_off  = 1'b1;
                        end
                        default:
                        begin
                            // unknown code: state unchanged, status ok
                        end
                    endcase
                end
            end
            S_SCALE:
            begin
                if (done_l)
                begin
                    mag_l_next = q_l[MAG_W-1:0];
                    mag_r_next = q_r[MAG_W-1:0];
                    start_next = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (done_l)
                begin
                    cmp_l_next        = q_l;
                    cmp_r_next        = q_r;
                    pins_next[PIN_EN] = 1'b1;
                    pins_next[PIN_L1] = dir_l1;
                    pins_next[PIN_L2] = dir_l2;
                    pins_next[PIN_R1] = dir_r1;
                    pins_next[PIN_R2] = dir_r2;
                    mode_next         = MODE_COAST;
                    state_next        = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_next.pins   = pins_reg;
                    out_next.cmp_l  = cmp_l_reg;
                    out_next.cmp_r  = cmp_r_reg;
                    out_next.status = status_reg;
                    out_next.estop  = estop_reg;
                    out_next.mode   = mode_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (force_off)
        begin
            pins_next  = PINS_OFF;
            cmp_l_next = '0;
            cmp_r_next = '0;
            mode_next  = MODE_STANDBY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            period_reg    <= PERIOD_W'(1000);
            init_reg      <= 1'b0;
            estop_reg     <= 1'b0;
            mode_reg      <= MODE_STANDBY;
            pins_reg      <= PINS_OFF;
            cmp_l_reg     <= '0;
            cmp_r_reg     <= '0;
            status_reg    <= ST_OK;
            sgn_l_reg     <= 1'b0;
            sgn_r_reg     <= 1'b0;
            mag_l_reg     <= '0;
            mag_r_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            init_reg      <= init_next;
            estop_reg     <= estop_next;
            mode_reg      <= mode_next;
            pins_reg      <= pins_next;
            cmp_l_reg     <= cmp_l_next;
            cmp_r_reg     <= cmp_r_next;
            status_reg    <= status_next;
            sgn_l_reg     <= sgn_l_next;
            sgn_r_reg     <= sgn_r_next;
            mag_l_reg     <= mag_l_next;
            mag_r_reg     <= mag_r_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // ---- result word ----
    assign out_valid         = out_valid_reg;
    assign bridge_enable     = out_reg.pins[PIN_EN];
    assign left_in1          = out_reg.pins[PIN_L1];
    assign left_in2          = out_reg.pins[PIN_L2];
    assign right_in1         = out_reg.pins[PIN_R1];
    assign right_in2         = out_reg.pins[PIN_R2];
    assign left_compare      = out_reg.cmp_l;
    assign right_compare     = out_reg.cmp_r;
    assign status            = out_reg.status;
    assign emergency_latched = out_reg.estop;
    assign current_stop_mode = out_reg.mode;

`ifndef SYNTHESIS
    // an accepted command word always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("command accepted but core stayed idle");

    // emergency latch never clears outside reset
    a_estop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        estop_reg |=> estop_reg)
        else $error("emergency latch cleared");

    // with the latch set every reported output is off
    a_estop_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && emergency_latched |->
            !bridge_enable && left_compare == '0 && right_compare == '0)
        else $error("outputs live with emergency latched");

    // a lane pass ends only while the sequencer waits for it
    a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
        done_l |-> done_r && (state_reg == S_SCALE || state_reg == S_CMP))
        else $error("lane finished out of step");
`endif

endmodule

// ===== src/ddc_muldiv.sv =====
// ----------------------------------------------------------------------------
// ddc_muldiv: bit-serial multiply then divide, q = (a * b) / d
// Shift-add multiply, one multiplier bit a cycle, then restoring division,
// one quotient bit a cycle. Quotient must fit PERIOD_W bits.
// ----------------------------------------------------------------------------
module ddc_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ddc_pkg::PERIOD_W-1:0]  a,
    input  logic [ddc_pkg::MAG_W-1:0]     b,
    input  logic [ddc_pkg::MAG_W-1:0]     d,
    output logic                          done,
    output logic [ddc_pkg::PERIOD_W-1:0]  q
);
    import ddc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } mstate_t;

    mstate_t             state_reg,  state_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [PROD_W-1:0]   acc_reg,    acc_next;     // product, then dividend/quotient
    logic [PROD_W-1:0]   mcand_reg,  mcand_next;
    logic [MAG_W-1:0]    mplier_reg, mplier_next;
    logic [MAG_W-1:0]    dsr_reg,    dsr_next;
    logic [MAG_W-1:0]    rem_reg,    rem_next;
    logic                done_reg,   done_next;

    logic [MAG_W:0] rem_sh;
    logic [MAG_W:0] rem_sub;
    logic           fits;

    assign rem_sh  = {rem_reg, acc_reg[PROD_W-1]};
    assign fits    = (rem_sh >= {1'b0, dsr_reg});
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dsr_next    = dsr_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = PROD_W'(a);
                    mplier_next = b;
                    dsr_next    = d;
                    cnt_next    = '0;
                    state_next  = M_MUL;
                end
            end
            M_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MAG_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = M_DIV;
                end
            end
            M_DIV:
            begin
                rem_next = fits ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            dsr_reg    <= '0;
            rem_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
            dsr_reg    <= dsr_next;
            rem_reg    <= rem_next;
            done_reg   <= done_next;
        end
    end

    assign done = done_reg;
    assign q    = acc_reg[PERIOD_W-1:0];

endmodule

// ===== dv/dual_hbridge_motor_command_core_tb.sv =====
// ----------------------------------------------------------------------------
// dual_hbridge_motor_command_core_tb: self-checking bench for the command core
// Feeds command words through the valid/ready input, predicts pins, compares,
// status, latch and stop mode for each accepted word, and checks every result
// word in order. Both sides idle at random; the PWM period is swept between
// phases, including zero, one and values above the 65536 cap.
// ----------------------------------------------------------------------------
module dual_hbridge_motor_command_core_tb;

    import ddc_pkg::*;

    // codes the package has no name for
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam int RANDOM_PER_PHASE = 158;
    localparam int PHASES           = 9;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        logic [2:0]                op;
        logic signed [VALUE_W-1:0] v1;
        logic signed [VALUE_W-1:0] v2;
        logic [1:0]                stop_req;
        logic                      safe;
    } motor_cmd_t;

    // ---------------------------------------------------------------- DUT I/O
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [PERIOD_W-1:0]        cfg_wdata    = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [2:0]                 operation    = OP_INIT;
    logic signed [VALUE_W-1:0]  first_value  = '0;
    logic signed [VALUE_W-1:0]  second_value = '0;
    logic [1:0]                 stop_request = MODE_STANDBY;
    logic                       supply_safe  = 1'b0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic                       bridge_enable;
    logic                       left_in1;
    logic                       left_in2;
    logic                       right_in1;
    logic                       right_in2;
    logic [PERIOD_W-1:0]        left_compare;
    logic [PERIOD_W-1:0]        right_compare;
    logic [1:0]                 status;
    logic                       emergency_latched;
    logic [1:0]                 current_stop_mode;

    dual_hbridge_motor_command_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .first_value       (first_value),
        .second_value      (second_value),
        .stop_request      (stop_request),
        .supply_safe       (supply_safe),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .bridge_enable     (bridge_enable),
        .left_in1          (left_in1),
        .left_in2          (left_in2),
        .right_in1         (right_in1),
        .right_in2         (right_in2),
        .left_compare      (left_compare),
        .right_compare     (right_compare),
        .status            (status),
        .emergency_latched (emergency_latched),
        .current_stop_mode (current_stop_mode)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------ bench state
    motor_cmd_t cmd_backlog [$];        // words waiting for the driver
    result_t    expected_bridge [$];    // predicted result words, oldest first
    int         words_outstanding = 0;  // queued but not yet accepted
    bit         word_taken        = 1'b0;
    int         send_gap          = 0;
    int         recv_stall        = 0;
    int         calm_left         = 0;

    int words_queued    = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int periods_applied = 1;
    int n_ok            = 0;
    int n_not_init      = 0;
    int n_refused       = 0;

    // --------------------------------------------------------- bridge mirror
    logic [PERIOD_W-1:0] period_reg     = PERIOD_W'(1000);
    logic [4:0]          bridge_pins    = PINS_OFF;
    logic [PERIOD_W-1:0] duty_left      = '0;
    logic [PERIOD_W-1:0] duty_right     = '0;
    logic [1:0]          stop_mode_held = MODE_STANDBY;
    bit                  initialised    = 1'b0;
    bit                  estop_seen     = 1'b0;

    // zero period reads as one, anything past the cap as the cap
    function automatic int unsigned eff_period();
        if (period_reg == '0)
            return 1;
        if (period_reg > PERIOD_CAP)
            return 32'(PERIOD_CAP);
        return 32'(period_reg);
    endfunction

    function automatic int clamp_permille(int v);
        if (v > MAX_PERMILLE)
            return MAX_PERMILLE;
        if (v < -MAX_PERMILLE)
            return -MAX_PERMILLE;
        return v;
    endfunction

    function automatic int unsigned abs_level(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int rescale(int v, int unsigned peak);
        int unsigned q;
        q = (abs_level(v) * MAX_PERMILLE) / peak;
        return (v < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic void shut_bridges();
        bridge_pins    = PINS_OFF;
        duty_left      = '0;
        duty_right     = '0;
        stop_mode_held = MODE_STANDBY;
    endfunction

    function automatic logic [1:0] apply_stop(logic [1:0] req, logic safe);
        logic [1:0] m;
        m = (req > MODE_BRAKE) ? MODE_STANDBY : req;
        if (!initialised)
        begin
            shut_bridges();
            return ST_NOT_INIT;
        end
        if (estop_seen || (m != MODE_STANDBY && !safe))
        begin
            shut_bridges();
            return ST_REFUSED;
        end
        case (m)
            MODE_BRAKE:
            begin
                bridge_pins = PINS_ALL;
                duty_left   = PERIOD_W'(eff_period());
                duty_right  = PERIOD_W'(eff_period());
            end
            MODE_COAST:
            begin
                bridge_pins         = PINS_OFF;
                bridge_pins[PIN_EN] = 1'b1;
                duty_left           = PERIOD_W'(eff_period());
                duty_right          = PERIOD_W'(eff_period());
            end
            default:
            begin
                bridge_pins = PINS_OFF;
                duty_left   = '0;
                duty_right  = '0;
            end
        endcase
        stop_mode_held = m;
        return ST_OK;
    endfunction

    function automatic logic [1:0] apply_levels(int l_in, int r_in, logic safe);
        int l;
        int r;
        if (!initialised)
            return ST_NOT_INIT;
        l = clamp_permille(l_in);
        r = clamp_permille(r_in);
        // both sides at zero behaves as a standby stop
        if (l == 0 && r == 0)
            return apply_stop(MODE_STANDBY, safe);
        if (estop_seen || !safe)
        begin
            shut_bridges();
            return ST_REFUSED;
        end
        bridge_pins         = PINS_OFF;
        bridge_pins[PIN_EN] = 1'b1;
        if (l > 0)
            bridge_pins[PIN_L1] = 1'b1;
        else if (l < 0)
            bridge_pins[PIN_L2] = 1'b1;
        if (r > 0)
            bridge_pins[PIN_R1] = 1'b1;
        else if (r < 0)
            bridge_pins[PIN_R2] = 1'b1;
        duty_left      = PERIOD_W'((eff_period() * abs_level(l)) / MAX_PERMILLE);
        duty_right     = PERIOD_W'((eff_period() * abs_level(r)) / MAX_PERMILLE);
        stop_mode_held = MODE_COAST;
        return ST_OK;
    endfunction

    // Advances the mirror by one accepted word and returns the result it owes
    function automatic result_t predict_bridge(logic [2:0] op, int v1, int v2,
                                               logic [1:0] req, logic safe);
        result_t     res;
        logic [1:0]  st;
        int          lin;
        int          turn;
        int          l;
        int          r;
        int unsigned peak;
        st = ST_OK;
        case (op)
            OP_INIT:
            begin
                shut_bridges();
                if (estop_seen || !safe)
                    st = ST_REFUSED;
                else
                    initialised = 1'b1;
            end
            OP_SET_OUTPUT:
                st = apply_levels(v1, v2, safe);
            OP_DRIVE:
            begin
                // differential mix, then rescale by the larger magnitude when it exceeds full scale
                lin  = clamp_permille(v1);
                turn = clamp_permille(v2);
                l    = lin - turn;
                r    = lin + turn;
                peak = (abs_level(r) > abs_level(l)) ? abs_level(r) : abs_level(l);
                if (peak > MAX_PERMILLE)
                begin
                    l = rescale(l, peak);
                    r = rescale(r, peak);
                end
                st = apply_levels(l, r, safe);
            end
            OP_STOP:
                st = apply_stop(req, safe);
            OP_ESTOP:
            begin
                estop_seen = 1'b1;
                shut_bridges();
            end
            default:
                ;   // spare codes leave everything as it is
        endcase
        res.pins   = bridge_pins;
        res.cmp_l  = duty_left;
        res.cmp_r  = duty_right;
        res.status = st;
        res.estop  = estop_seen;
        res.mode   = stop_mode_held;
        return res;
    endfunction

    // ------------------------------------------------------- stimulus helpers
    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_permille();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
            v = 0;
        else if (r < 60)
            v = int'($urandom_range(0, 2 * MAX_PERMILLE)) - MAX_PERMILLE;
        else if (r < 75)
            // around the clamp point
            v = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(990, 1010));
        else if (r < 85)
            case ($urandom_range(0, 5))
                0:       v = 32767;
                1:       v = -32768;
                2:       v = MAX_PERMILLE;
                3:       v = -MAX_PERMILLE;
                4:       v = 1;
                default: v = -1;
            endcase
        else
            v = $urandom;
        return VALUE_W'(v);
    endfunction

    function automatic motor_cmd_t make_word(logic [2:0] op, int v1, int v2,
                                             logic [1:0] req, logic safe);
        motor_cmd_t c;
        c.op       = op;
        c.v1       = VALUE_W'(v1);
        c.v2       = VALUE_W'(v2);
        c.stop_req = req;
        c.safe     = safe;
        return c;
    endfunction

    // Emergency stop latches for the rest of the run, so it only appears
    // in the closing section.
    function automatic motor_cmd_t random_word(bit with_estop);
        motor_cmd_t c;
        int         r;
        r = $urandom_range(0, 99);
        if (with_estop && r < 10)
            c.op = OP_ESTOP;
        else if (r < 18)
            c.op = OP_INIT;
        else if (r < 46)
            c.op = OP_SET_OUTPUT;
        else if (r < 74)
            c.op = OP_DRIVE;
        else if (r < 94)
            c.op = OP_STOP;
        else
            c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        c.v1 = pick_permille();
        c.v2 = pick_permille();
        if ($urandom_range(0, 24) == 0)
        begin
            c.v1 = '0;
            c.v2 = '0;
        end
        c.stop_req = 2'($urandom_range(0, 3));
        c.safe     = ($urandom_range(0, 9) != 0);
        return c;
    endfunction

    task automatic queue_word(input motor_cmd_t c);
        cmd_backlog.push_back(c);
        words_outstanding++;
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_outstanding != 0 || expected_bridge.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] counts);
        @(negedge clk);
        cfg_wdata <= counts;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we     <= 1'b0;
        period_reg  = counts;
        periods_applied++;
    endtask

    // ----------------------------------------------------------------- driver
    // Payload moves on the falling edge; a word stays put until accepted.
    always @(negedge clk)
    begin : feed_commands
        motor_cmd_t c;
        if (rst_n)
        begin
            if (!(in_valid && !word_taken))
            begin
                word_taken = 1'b0;
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    c             = cmd_backlog.pop_front();
                    operation    <= c.op;
                    first_value  <= c.v1;
                    second_value <= c.v2;
                    stop_request <= c.stop_req;
                    supply_safe  <= c.safe;
                    in_valid     <= 1'b1;
                    send_gap      = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            // result side back-pressure
            if (recv_stall > 0)
            begin
                out_ready <= 1'b0;
                recv_stall--;
            end
            else
            begin
                out_ready  <= 1'b1;
                recv_stall  = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch in %s on result word %0d: expected %0d, got %0d",
                         name, results_checked, want, got);
        end
    endfunction

    // Results are taken before the new word is predicted; a result can never
    // belong to a word accepted on the same edge.
    always @(posedge clk)
    begin : watch_results
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bridge.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result word with no command outstanding (status %0d)",
                                 status);
                end
                else
                begin
                    want = expected_bridge.pop_front();
                    check_field("bridge_enable", want.pins[PIN_EN], bridge_enable);
                    check_field("left_in1", want.pins[PIN_L1], left_in1);
                    check_field("left_in2", want.pins[PIN_L2], left_in2);
                    check_field("right_in1", want.pins[PIN_R1], right_in1);
                    check_field("right_in2", want.pins[PIN_R2], right_in2);
                    check_field("left_compare", want.cmp_l, left_compare);
                    check_field("right_compare", want.cmp_r, right_compare);
                    check_field("status", want.status, status);
                    check_field("emergency_latched", want.estop, emergency_latched);
                    check_field("current_stop_mode", want.mode, current_stop_mode);
                    results_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_bridge(operation, first_value, second_value,
                                      stop_request, supply_safe);
                case (want.status)
                    ST_OK:       n_ok++;
                    ST_NOT_INIT: n_not_init++;
                    default:     n_refused++;
                endcase
                expected_bridge.push_back(want);
                words_outstanding--;
                word_taken = 1'b1;
            end
        end
    end

    // -------------------------------------------------------------- sequence
    initial
    begin : run_sequence
        logic [PERIOD_W-1:0] period_plan [1:PHASES-1];

        // period sweep: degenerate, full cap, above cap, odd, back to default
        period_plan[1] = PERIOD_W'(1);
        period_plan[2] = '0;
        period_plan[3] = PERIOD_CAP;
        period_plan[4] = '1;
        period_plan[5] = PERIOD_W'(65535);
        period_plan[6] = PERIOD_W'(7);
        period_plan[7] = PERIOD_W'($urandom_range(2, 65535));
        period_plan[8] = PERIOD_W'(1000);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: nothing initialised yet, then a refused and an accepted init
        queue_word(make_word(OP_SET_OUTPUT, 500, 500, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_STOP, 0, 0, MODE_BRAKE, 1'b1));
        queue_word(make_word(OP_DRIVE, 300, 100, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_INIT, 0, 0, MODE_STANDBY, 1'b0));
        queue_word(make_word(OP_SPARE_HI, 0, 0, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_INIT, 0, 0, MODE_STANDBY, 1'b1));
        // set output: full scale, clamping, zero pair, smallest step, one side idle, a spare code, unsafe supply
        queue_word(make_word(OP_SET_OUTPUT, 1000, -1000, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_SET_OUTPUT, 32767, -32768, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_SET_OUTPUT, 0, 0, MODE_BRAKE, 1'b1));
        queue_word(make_word(OP_SET_OUTPUT, 1, -1, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_SET_OUTPUT, 500, 0, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_SPARE_LO, -7, 9, MODE_BRAKE, 1'b1));
        queue_word(make_word(OP_SET_OUTPUT, 300, 300, MODE_STANDBY, 1'b0));
        queue_word(make_word(OP_SET_OUTPUT, 0, 0, MODE_STANDBY, 1'b0));
        // drive: rescale on either side, clamped extremes, zero, exactly full scale
        queue_word(make_word(OP_DRIVE, 1000, 1000, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_DRIVE, 700, -500, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_DRIVE, -32768, 32767, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_DRIVE, 300, 100, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_DRIVE, 0, 0, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_DRIVE, 500, 500, MODE_STANDBY, 1'b1));
        // stop modes, the spare mode, and refusals on an unsafe supply
        queue_word(make_word(OP_STOP, 0, 0, MODE_BRAKE, 1'b1));
        queue_word(make_word(OP_STOP, 0, 0, MODE_COAST, 1'b1));
        queue_word(make_word(OP_STOP, 0, 0, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_STOP, 0, 0, MODE_SPARE, 1'b1));
        queue_word(make_word(OP_STOP, 0, 0, MODE_BRAKE, 1'b0));
        queue_word(make_word(OP_STOP, 0, 0, MODE_STANDBY, 1'b0));
        queue_word(make_word(OP_STOP, 0, 0, MODE_COAST, 1'b0));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                // register only touched once the core has drained
                wait_idle();
                set_period(period_plan[p]);
            end
            queue_word(make_word(OP_INIT, 0, 0, MODE_STANDBY, 1'b1));
            repeat (RANDOM_PER_PHASE) queue_word(random_word(1'b0));
        end

        // closing section: emergency stop latches; every later init, output and stop is refused
        queue_word(make_word(OP_SET_OUTPUT, -600, 800, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_ESTOP, 0, 0, MODE_STANDBY, 1'b0));
        queue_word(make_word(OP_INIT, 0, 0, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_SET_OUTPUT, 400, 400, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_DRIVE, 200, 50, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_STOP, 0, 0, MODE_STANDBY, 1'b1));
        queue_word(make_word(OP_STOP, 0, 0, MODE_BRAKE, 1'b1));
        queue_word(make_word(OP_ESTOP, 1, 1, MODE_BRAKE, 1'b1));
        queue_word(make_word(OP_SPARE_LO, 0, 0, MODE_STANDBY, 1'b1));
        repeat (20) queue_word(random_word(1'b1));

        wait_idle();
        // allow for a stray extra result after the last one expected
        repeat (100) @(negedge clk);

        $display("Sent %0d command words over %0d PWM period settings; %0d results compared.",
                 words_queued, periods_applied, results_checked);
        $display("Outcomes: %0d accepted, %0d refused uninitialised, %0d refused unsafe/latched.",
                 n_ok, n_not_init, n_refused);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog: generous bound on the slowest legal run
    initial
    begin : watchdog
        #2000000;
        $display("timeout with %0d words outstanding and %0d results awaited",
                 words_outstanding, expected_bridge.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== dual_hbridge_motor_command_core.f =====
src/ddc_pkg.sv
src/ddc_muldiv.sv
src/dual_hbridge_motor_command_core.sv
dv/dual_hbridge_motor_command_core_tb.sv
